[rtl/core/fprc16_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc16_pkg
// Shared types and constants for the framed packet receiver with CRC-16 check.
// ----------------------------------------------------------------------------
package fprc16_pkg;

  // header layout
  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned HDR_IDX_W  = 3;
  localparam int unsigned HDR_VER    = 0;
  localparam int unsigned HDR_FLAGS  = 1;
  localparam int unsigned HDR_CMD_LO = 2;
  localparam int unsigned HDR_CMD_HI = 3;
  localparam int unsigned HDR_SEQ_LO = 4;
  localparam int unsigned HDR_SEQ_HI = 5;
  localparam int unsigned HDR_LEN_LO = 6;
  localparam int unsigned HDR_LEN_HI = 7;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_FIRST  = 2'd0,
    CFG_START_SECOND = 2'd1,
    CFG_EXP_VERSION  = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] RST_START_FIRST  = 8'hAA;
  localparam logic [7:0] RST_START_SECOND = 8'h55;
  localparam logic [7:0] RST_EXP_VERSION  = 8'h01;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HEAD,
    PH_BODY,
    PH_CHECK
  } phase_e;

  // result emitter state
  typedef enum logic [1:0] {
    EM_IDLE,
    EM_ONE,
    EM_DATA
  } emit_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_GOOD        = 2'd0,
    ST_CRC_BAD     = 2'd1,
    ST_VERSION_BAD = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_e;

  // input beat
  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_beat_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] command;
    logic [15:0] sequence_res;
    logic [7:0]  frame_flags;
    logic [7:0]  version_seen;
    logic [15:0] length;
    logic        has_data;
    logic [7:0]  data_byte;
    logic [4:0]  byte_index;
    logic        last;
  } res_beat_t;

endpackage
`default_nettype wire

[rtl/core/fprc16_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprc16_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface fprc16_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/framed_packet_receiver_crc16_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_unit
// Framed byte-stream receiver: start-marker hunt, 8-byte header, payload
// buffered in a synchronous RAM, running CRC-16/CCITT-FALSE check, and
// emission of the payload (or one status beat) once the frame ends.
// ----------------------------------------------------------------------------
// Output: a status beat (error or empty frame) goes from the emitter state,
//   set by the byte that ends the frame, to the output register; payload
//   beats pass a RAM read, then the output register, and follow at one per
//   cycle while res_o is ready. Throughput: one byte per cycle while parsing;
//   after a frame ends the input is held off until its last beat is loaded.
// Reset: parser, emitter and config registers return to defaults; the
//   payload RAM and header bytes are not cleared.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_unit #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [fprc16_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [7:0]                          cfg_wdata_i,
  fprc16_stream_if.sink                            rx_i,
  fprc16_stream_if.source                          res_o
);

  // count width holds 0..MAX_PAYLOAD, address width indexes the RAM
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // one byte of CRC-16 update, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ fprc16_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // configuration registers
  logic [7:0] start_first_q, start_second_q, exp_version_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= fprc16_pkg::RST_START_FIRST;
      start_second_q <= fprc16_pkg::RST_START_SECOND;
      exp_version_q  <= fprc16_pkg::RST_EXP_VERSION;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fprc16_pkg::CFG_START_FIRST)  start_first_q  <= cfg_wdata_i;
      if (cfg_idx_i == fprc16_pkg::CFG_START_SECOND) start_second_q <= cfg_wdata_i;
      if (cfg_idx_i == fprc16_pkg::CFG_EXP_VERSION)  exp_version_q  <= cfg_wdata_i;
    end
  end

  // parser state
  fprc16_pkg::phase_e                phase_q, phase_d;
  logic [fprc16_pkg::HDR_IDX_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [CW-1:0]                     pay_cnt_q, pay_cnt_d;
  logic                              crc_lo_seen_q, crc_lo_seen_d;
  logic [7:0]                        crc_lo_q, crc_lo_d;
  logic [15:0]                       crc_q, crc_d;
  logic [7:0]                        hdr_q [fprc16_pkg::HDR_BYTES];

  // emitter state
  fprc16_pkg::emit_e                 em_st_q, em_st_d;
  fprc16_pkg::status_e               em_status_q, em_status_d;
  logic [CW-1:0]                     em_len_q, em_len_d;
  logic [CW-1:0]                     iss_cnt_q, iss_cnt_d;
  logic                              stg_vld_q, stg_vld_d;
  logic [CW-1:0]                     stg_idx_q, stg_idx_d;
  logic [7:0]                        stg_data_q;

  // output register
  logic                              out_vld_q, out_vld_d;
  fprc16_pkg::res_beat_t             out_q, out_d;

  // payload RAM
  logic [7:0]                        pay_mem [MAX_PAYLOAD];

  logic        rx_fire;
  logic [7:0]  rx_b;
  logic [15:0] crc_next;
  logic [15:0] hdr_len;
  logic [15:0] hdr_len_now;
  logic        hdr_we;
  logic        mem_we;
  logic        issue;
  logic        out_free;
  logic        out_load;

  assign rx_b        = rx_i.payload.rx_byte;
  assign rx_fire     = rx_i.valid && rx_i.ready;
  assign crc_next    = crc_byte(crc_q, rx_b);
  assign hdr_len     = {hdr_q[fprc16_pkg::HDR_LEN_HI], hdr_q[fprc16_pkg::HDR_LEN_LO]};
  assign hdr_len_now = {rx_b, hdr_q[fprc16_pkg::HDR_LEN_LO]};
  assign out_free    = !out_vld_q || res_o.ready;

  // input is taken only while no frame result is pending
  assign rx_i.ready    = (em_st_q == fprc16_pkg::EM_IDLE);
  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  // parser and emitter next state
  always_comb begin
    phase_d       = phase_q;
    hdr_cnt_d     = hdr_cnt_q;
    pay_cnt_d     = pay_cnt_q;
    crc_lo_seen_d = crc_lo_seen_q;
    crc_lo_d      = crc_lo_q;
    crc_d         = crc_q;
    hdr_we        = 1'b0;
    mem_we        = 1'b0;
    em_st_d       = em_st_q;
    em_status_d   = em_status_q;
    em_len_d      = em_len_q;
    iss_cnt_d     = iss_cnt_q;
    stg_vld_d     = stg_vld_q;
    stg_idx_d     = stg_idx_q;
    issue         = 1'b0;
    out_load      = 1'b0;
    out_d         = out_q;

    // header fields shared by every result beat
    out_d.command      = {hdr_q[fprc16_pkg::HDR_CMD_HI], hdr_q[fprc16_pkg::HDR_CMD_LO]};
    out_d.sequence_res = {hdr_q[fprc16_pkg::HDR_SEQ_HI], hdr_q[fprc16_pkg::HDR_SEQ_LO]};
    out_d.frame_flags  = hdr_q[fprc16_pkg::HDR_FLAGS];
    out_d.version_seen = hdr_q[fprc16_pkg::HDR_VER];
    out_d.length       = hdr_len;

    // byte parser
    if (rx_fire) begin
      case (phase_q)
        fprc16_pkg::PH_HUNT1: begin
          if (rx_b == start_first_q) phase_d = fprc16_pkg::PH_HUNT2;
        end
        fprc16_pkg::PH_HUNT2: begin
          if (rx_b == start_second_q) begin
            phase_d   = fprc16_pkg::PH_HEAD;
            hdr_cnt_d = '0;
            crc_d     = fprc16_pkg::CRC_INIT;
          end else if (rx_b != start_first_q) begin
            phase_d = fprc16_pkg::PH_HUNT1;
          end
        end
        fprc16_pkg::PH_HEAD: begin
          hdr_we    = 1'b1;
          hdr_cnt_d = hdr_cnt_q + 1'b1;
          crc_d     = crc_next;
          if (hdr_cnt_q == fprc16_pkg::HDR_IDX_W'(fprc16_pkg::HDR_BYTES - 1)) begin
            if (hdr_q[fprc16_pkg::HDR_VER] != exp_version_q) begin
              em_st_d     = fprc16_pkg::EM_ONE;
              em_status_d = fprc16_pkg::ST_VERSION_BAD;
              phase_d     = fprc16_pkg::PH_HUNT1;
              crc_d       = fprc16_pkg::CRC_INIT;
            end else if (hdr_len_now > 16'(MAX_PAYLOAD)) begin
              em_st_d     = fprc16_pkg::EM_ONE;
              em_status_d = fprc16_pkg::ST_TOO_LONG;
              phase_d     = fprc16_pkg::PH_HUNT1;
              crc_d       = fprc16_pkg::CRC_INIT;
            end else begin
              pay_cnt_d     = '0;
              crc_lo_seen_d = 1'b0;
              phase_d       = (hdr_len_now == 16'd0) ? fprc16_pkg::PH_CHECK
                                                     : fprc16_pkg::PH_BODY;
            end
          end
        end
        fprc16_pkg::PH_BODY: begin
          mem_we    = 1'b1;
          pay_cnt_d = pay_cnt_q + 1'b1;
          crc_d     = crc_next;
          if ((16'(pay_cnt_q) + 16'd1 >= hdr_len) ||
              (pay_cnt_q == CW'(MAX_PAYLOAD - 1))) begin
            phase_d       = fprc16_pkg::PH_CHECK;
            crc_lo_seen_d = 1'b0;
          end
        end
        fprc16_pkg::PH_CHECK: begin
          if (!crc_lo_seen_q) begin
            crc_lo_d      = rx_b;
            crc_lo_seen_d = 1'b1;
          end else begin
            if ({rx_b, crc_lo_q} != crc_q) begin
              em_st_d     = fprc16_pkg::EM_ONE;
              em_status_d = fprc16_pkg::ST_CRC_BAD;
            end else if (hdr_len == 16'd0) begin
              em_st_d     = fprc16_pkg::EM_ONE;
              em_status_d = fprc16_pkg::ST_GOOD;
            end else begin
              em_st_d   = fprc16_pkg::EM_DATA;
              em_len_d  = hdr_len[CW-1:0];
              iss_cnt_d = '0;
            end
            phase_d       = fprc16_pkg::PH_HUNT1;
            hdr_cnt_d     = '0;
            pay_cnt_d     = '0;
            crc_lo_seen_d = 1'b0;
            crc_d         = fprc16_pkg::CRC_INIT;
          end
        end
        default: begin
          phase_d       = fprc16_pkg::PH_HUNT1;
          hdr_cnt_d     = '0;
          pay_cnt_d     = '0;
          crc_lo_seen_d = 1'b0;
          crc_d         = fprc16_pkg::CRC_INIT;
        end
      endcase
    end

    // result emitter
    case (em_st_q)
      fprc16_pkg::EM_ONE: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.status     = em_status_q;
          out_d.has_data   = 1'b0;
          out_d.data_byte  = 8'd0;
          out_d.byte_index = 5'd0;
          out_d.last       = 1'b1;
          em_st_d          = fprc16_pkg::EM_IDLE;
        end
      end
      fprc16_pkg::EM_DATA: begin
        // staged RAM word moves to the output register
        if (stg_vld_q && out_free) begin
          out_load         = 1'b1;
          out_d.status     = fprc16_pkg::ST_GOOD;
          out_d.has_data   = 1'b1;
          out_d.data_byte  = stg_data_q;
          out_d.byte_index = 5'(stg_idx_q);
          out_d.last       = (stg_idx_q + 1'b1 == em_len_q);
          stg_vld_d        = 1'b0;
          if (stg_idx_q + 1'b1 == em_len_q) em_st_d = fprc16_pkg::EM_IDLE;
        end
        // next RAM read when the stage is free or drains this cycle
        if ((iss_cnt_q != em_len_q) && (!stg_vld_q || out_free)) begin
          issue     = 1'b1;
          stg_vld_d = 1'b1;
          stg_idx_d = iss_cnt_q;
          iss_cnt_d = iss_cnt_q + 1'b1;
        end
      end
      default: ;
    endcase

    out_vld_d = out_load || (out_vld_q && !res_o.ready);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= fprc16_pkg::PH_HUNT1;
      hdr_cnt_q     <= '0;
      pay_cnt_q     <= '0;
      crc_lo_seen_q <= 1'b0;
      crc_lo_q      <= 8'd0;
      crc_q         <= fprc16_pkg::CRC_INIT;
      em_st_q       <= fprc16_pkg::EM_IDLE;
      em_status_q   <= fprc16_pkg::ST_GOOD;
      em_len_q      <= '0;
      iss_cnt_q     <= '0;
      stg_vld_q     <= 1'b0;
      stg_idx_q     <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      hdr_cnt_q     <= hdr_cnt_d;
      pay_cnt_q     <= pay_cnt_d;
      crc_lo_seen_q <= crc_lo_seen_d;
      crc_lo_q      <= crc_lo_d;
      crc_q         <= crc_d;
      em_st_q       <= em_st_d;
      em_status_q   <= em_status_d;
      em_len_q      <= em_len_d;
      iss_cnt_q     <= iss_cnt_d;
      stg_vld_q     <= stg_vld_d;
      stg_idx_q     <= stg_idx_d;
      out_vld_q     <= out_vld_d;
    end
  end

  // header and output registers
  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_q[hdr_cnt_q] <= rx_b;
    if (out_load) out_q <= out_d;
  end

  // payload RAM: writes happen only while parsing, reads only while
  // emitting with input held off, so the two never touch the same cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) pay_mem[pay_cnt_q[AW-1:0]] <= rx_b;
    if (issue) stg_data_q <= pay_mem[iss_cnt_q[AW-1:0]];
  end

  // checks
  a_body_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == fprc16_pkg::PH_BODY) |-> (pay_cnt_q < CW'(MAX_PAYLOAD)))
    else $error("payload count ran past the buffer");

  a_emit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_st_q == fprc16_pkg::EM_DATA) |-> (em_len_q != '0))
    else $error("data emission with empty length");

  a_stage_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q |-> (stg_idx_q < em_len_q) && (em_st_q == fprc16_pkg::EM_DATA))
    else $error("staged index outside the frame");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> (em_st_q == fprc16_pkg::EM_IDLE) && !stg_vld_q)
    else $error("emitter busy after last beat");

  a_no_write_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_st_q != fprc16_pkg::EM_IDLE) |-> !mem_we && !hdr_we)
    else $error("frame storage written during emission");

endmodule
`default_nettype wire

[test/framed_packet_receiver_crc16_unit_tb.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_unit_tb
// Self-checking bench for the framed packet receiver. A short table of
// hand-picked bytes covers marker hunting and the header error codes. Random
// frames follow, under three marker/version settings and three stall mixes.
// Each accepted byte runs through a behavioral parser that queues the result
// beats it should cause, and every result beat is checked against that queue.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_unit_tb;
  import fprc16_pkg::*;

  localparam int unsigned MAX_PAYLOAD       = 32;
  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT       = 200000;
  localparam int unsigned PHASE_BYTES       = 40;

  // index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    ROW_BY_MODEL,
    ROW_NO_RESULT,
    ROW_ONE_RESULT
  } row_mode_e;

  typedef struct packed {
    logic [7:0] rx;
    row_mode_e  mode;
    res_beat_t  want;
  } stim_row_t;

  localparam res_beat_t VER_BAD_RES = '{
    status: ST_VERSION_BAD, command: 16'hFFFF, sequence_res: 16'hFFFF,
    frame_flags: 8'hFF, version_seen: 8'hFF, length: 16'hFFFF,
    has_data: 1'b0, data_byte: 8'h00, byte_index: 5'd0, last: 1'b1};

  localparam res_beat_t TOO_LONG_RES = '{
    status: ST_TOO_LONG, command: 16'h0000, sequence_res: 16'h0000,
    frame_flags: 8'h00, version_seen: 8'h01, length: 16'h0021,
    has_data: 1'b0, data_byte: 8'h00, byte_index: 5'd0, last: 1'b1};

  // directed bytes, reset marker and version settings
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{8'h00, ROW_NO_RESULT,  '0},           // noise after reset
    '{8'hAA, ROW_NO_RESULT,  '0},
    '{8'h00, ROW_NO_RESULT,  '0},           // breaks the marker, back to hunt
    '{8'hAA, ROW_NO_RESULT,  '0},
    '{8'hAA, ROW_NO_RESULT,  '0},           // repeated first marker
    '{8'h55, ROW_NO_RESULT,  '0},
    '{8'hFF, ROW_BY_MODEL,   '0},           // version mismatch
    '{8'hFF, ROW_BY_MODEL,   '0},
    '{8'hFF, ROW_BY_MODEL,   '0},
    '{8'hFF, ROW_BY_MODEL,   '0},
    '{8'hFF, ROW_BY_MODEL,   '0},
    '{8'hFF, ROW_BY_MODEL,   '0},
    '{8'hFF, ROW_BY_MODEL,   '0},
    '{8'hFF, ROW_ONE_RESULT, VER_BAD_RES},  // oversize too, version wins
    '{8'hAA, ROW_BY_MODEL,   '0},
    '{8'h55, ROW_BY_MODEL,   '0},
    '{8'h01, ROW_BY_MODEL,   '0},
    '{8'h00, ROW_BY_MODEL,   '0},
    '{8'h00, ROW_BY_MODEL,   '0},
    '{8'h00, ROW_BY_MODEL,   '0},
    '{8'h00, ROW_BY_MODEL,   '0},
    '{8'h00, ROW_BY_MODEL,   '0},
    '{8'h21, ROW_BY_MODEL,   '0},           // length one above the limit
    '{8'h00, ROW_ONE_RESULT, TOO_LONG_RES}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_wdata_i;

  fprc16_stream_if #(.T(rx_beat_t))  rx_ch ();
  fprc16_stream_if #(.T(res_beat_t)) res_ch ();

  framed_packet_receiver_crc16_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_ch),
    .res_o      (res_ch)
  );

  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 81;

  // parser copy: marker/version settings and frame state
  logic [7:0]  cfg_sof1;
  logic [7:0]  cfg_sof2;
  logic [7:0]  cfg_version;
  phase_e      prs_phase;
  logic [7:0]  seen_hdr [HDR_BYTES];
  logic [7:0]  seen_payload [MAX_PAYLOAD];
  int unsigned hdr_cnt;
  int unsigned body_cnt;
  logic        crc_lo_seen;
  logic [15:0] rx_crc;
  logic [15:0] run_crc;

  res_beat_t   step_results [$];
  res_beat_t   due_results [$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [15:0] hdr_word(int unsigned pos);
    return {seen_hdr[pos + 1], seen_hdr[pos]};
  endfunction

  function automatic res_beat_t frame_result(status_e st, logic has, logic [7:0] d,
                                             logic [4:0] idx, logic last);
    res_beat_t r;
    r.status       = st;
    r.command      = hdr_word(HDR_CMD_LO);
    r.sequence_res = hdr_word(HDR_SEQ_LO);
    r.frame_flags  = seen_hdr[HDR_FLAGS];
    r.version_seen = seen_hdr[HDR_VER];
    r.length       = hdr_word(HDR_LEN_LO);
    r.has_data     = has;
    r.data_byte    = d;
    r.byte_index   = idx;
    r.last         = last;
    return r;
  endfunction

  function automatic void clear_frame();
    prs_phase   = PH_HUNT1;
    hdr_cnt     = 0;
    body_cnt    = 0;
    crc_lo_seen = 1'b0;
    rx_crc      = 16'h0000;
    run_crc     = CRC_INIT;
  endfunction

  // one received byte through the parser; result beats land in step_results
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0] len;
    step_results.delete();
    case (prs_phase)
      PH_HUNT1: begin
        if (b == cfg_sof1) prs_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == cfg_sof2) begin
          prs_phase = PH_HEAD;
          hdr_cnt   = 0;
          run_crc   = CRC_INIT;
        end else if (b != cfg_sof1) begin
          prs_phase = PH_HUNT1;
        end
      end
      PH_HEAD: begin
        seen_hdr[hdr_cnt] = b;
        hdr_cnt++;
        run_crc = crc16_byte(run_crc, b);
        if (hdr_cnt >= HDR_BYTES) begin
          len = hdr_word(HDR_LEN_LO);
          if (seen_hdr[HDR_VER] != cfg_version) begin
            step_results.push_back(frame_result(ST_VERSION_BAD, 1'b0, 8'h00, 5'd0, 1'b1));
            clear_frame();
          end else if (len > MAX_PAYLOAD) begin
            step_results.push_back(frame_result(ST_TOO_LONG, 1'b0, 8'h00, 5'd0, 1'b1));
            clear_frame();
          end else begin
            body_cnt    = 0;
            crc_lo_seen = 1'b0;
            rx_crc      = 16'h0000;
            prs_phase   = (len == 0) ? PH_CHECK : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (body_cnt < MAX_PAYLOAD) seen_payload[body_cnt] = b;
        body_cnt++;
        run_crc = crc16_byte(run_crc, b);
        if (body_cnt >= hdr_word(HDR_LEN_LO) || body_cnt >= MAX_PAYLOAD) begin
          prs_phase   = PH_CHECK;
          crc_lo_seen = 1'b0;
          rx_crc      = 16'h0000;
        end
      end
      PH_CHECK: begin
        if (!crc_lo_seen) begin
          rx_crc      = {8'h00, b};
          crc_lo_seen = 1'b1;
        end else begin
          rx_crc[15:8] = b;
          if (rx_crc != run_crc) begin
            step_results.push_back(frame_result(ST_CRC_BAD, 1'b0, 8'h00, 5'd0, 1'b1));
          end else begin
            len = hdr_word(HDR_LEN_LO);
            if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
            if (len == 0)
              step_results.push_back(frame_result(ST_GOOD, 1'b0, 8'h00, 5'd0, 1'b1));
            for (int unsigned i = 0; i < len; i++)
              step_results.push_back(frame_result(ST_GOOD, 1'b1, seen_payload[i], 5'(i),
                                                  (i + 1 == len)));
          end
          clear_frame();
        end
      end
      default: clear_frame();
    endcase
  endtask

  // one rx beat, with an optional idle gap first; valid stays up after accept
  task automatic send_byte(input logic [7:0] b, input row_mode_e mode, input res_beat_t want);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.payload <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    bytes_sent++;
    parse_rx_byte(b);
    case (mode)
      ROW_BY_MODEL:   foreach (step_results[i]) due_results.push_back(step_results[i]);
      ROW_ONE_RESULT: due_results.push_back(want);
      default: ;
    endcase
  endtask

  // stop sending and let every due result beat come out
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write; write enable is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_START_FIRST:  cfg_sof1    = val;
      CFG_START_SECOND: cfg_sof2    = val;
      CFG_EXP_VERSION:  cfg_version = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [7:0] sof1, input logic [7:0] sof2,
                             input logic [7:0] ver);
    write_reg(CFG_START_FIRST, sof1);
    write_reg(CFG_START_SECOND, sof2);
    write_reg(CFG_EXP_VERSION, ver);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed frame with random content; some bad CRCs, bad headers
  // and truncated frames mixed in
  task automatic send_random_frame();
    logic [7:0]  frame_q [$];
    logic [7:0]  hdr [HDR_BYTES];
    logic [7:0]  pl;
    logic [15:0] len_field;
    logic [15:0] crc;
    int unsigned pick;
    int unsigned n_keep;
    crc = CRC_INIT;
    repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), ROW_BY_MODEL, '0);
    send_byte(cfg_sof1, ROW_BY_MODEL, '0);
    if (cfg_sof1 != cfg_sof2 && $urandom_range(4) == 0)
      send_byte(cfg_sof1, ROW_BY_MODEL, '0);
    send_byte(cfg_sof2, ROW_BY_MODEL, '0);

    pick = $urandom_range(99);
    if (pick < 8)       len_field = 16'($urandom_range(65535, MAX_PAYLOAD + 1));
    else if (pick < 16) len_field = 16'(MAX_PAYLOAD);
    else                len_field = 16'($urandom_range(6));

    hdr[HDR_VER]    = ($urandom_range(9) == 0) ? cfg_version ^ 8'($urandom_range(255, 1))
                                               : cfg_version;
    hdr[HDR_FLAGS]  = 8'($urandom_range(255));
    hdr[HDR_CMD_LO] = 8'($urandom_range(255));
    hdr[HDR_CMD_HI] = 8'($urandom_range(255));
    hdr[HDR_SEQ_LO] = 8'($urandom_range(255));
    hdr[HDR_SEQ_HI] = 8'($urandom_range(255));
    hdr[HDR_LEN_LO] = len_field[7:0];
    hdr[HDR_LEN_HI] = len_field[15:8];
    foreach (hdr[i]) begin
      frame_q.push_back(hdr[i]);
      crc = crc16_byte(crc, hdr[i]);
    end

    // bad headers end at the last header byte: no payload, no CRC
    if (hdr[HDR_VER] == cfg_version && len_field <= MAX_PAYLOAD) begin
      repeat (len_field) begin
        pl = 8'($urandom_range(255));
        frame_q.push_back(pl);
        crc = crc16_byte(crc, pl);
      end
      if ($urandom_range(7) == 0) crc ^= 16'(1 << $urandom_range(15));
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
    end

    n_keep = frame_q.size();
    if ($urandom_range(19) == 0) n_keep = $urandom_range(n_keep - 1, 1);
    for (int unsigned i = 0; i < n_keep; i++) send_byte(frame_q[i], ROW_BY_MODEL, '0);
  endtask

  task automatic run_random(input int unsigned byte_goal);
    int unsigned start_bytes;
    int unsigned frames;
    start_bytes = bytes_sent;
    frames      = 0;
    while (bytes_sent - start_bytes < byte_goal) begin
      send_random_frame();
      frames++;
      if (frames % 4 == 0) drain_results();
    end
    drain_results();
  endtask

  // receiver stalls
  always @(posedge clk_i)
    res_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);

  // result beat checker
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    res_beat_t want;
    res_beat_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (due_results.size() == 0) begin
        $error("result beat with none due: status %0d length 0x%0h", got.status, got.length);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("command", want.command, got.command);
        check_field("sequence_res", want.sequence_res, got.sequence_res);
        check_field("frame_flags", want.frame_flags, got.frame_flags);
        check_field("version_seen", want.version_seen, got.version_seen);
        check_field("length", want.length, got.length);
        check_field("has_data", want.has_data, got.has_data);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("byte_index", want.byte_index, got.byte_index);
        check_field("last", want.last, got.last);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** framed_packet_receiver_crc16_unit: FAILED **");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_START_FIRST;
    cfg_wdata_i   <= 8'h00;
    rx_ch.valid   <= 1'b0;
    rx_ch.payload <= '0;
    cfg_sof1       = RST_START_FIRST;
    cfg_sof2       = RST_START_SECOND;
    cfg_version    = RST_EXP_VERSION;
    clear_frame();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table on reset settings
    foreach (DIRECTED_ROWS[i])
      send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].want);
    drain_results();

    // lightly idling sender, heavily stalled receiver; markers 0x00/0xFF, version 0x00
    write_reg(CFG_IDX_UNUSED, 8'hA5);
    load_config(8'h00, 8'hFF, 8'h00);
    run_random(PHASE_BYTES);

    // the other way round; both markers equal, top version
    send_idle_pct = 81;
    recv_idle_pct = 23;
    load_config(8'hFF, 8'hFF, 8'hFF);
    run_random(PHASE_BYTES);

    // no idling at all; random settings
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(PHASE_BYTES);

    if (fail_count == 0)
      $display("** framed_packet_receiver_crc16_unit: PASSED **");
    else
      $display("** framed_packet_receiver_crc16_unit: FAILED **");
    $finish;
  end

endmodule
